// File: rtl/hbp_pkg.sv
// Shared types, constants and helper functions for the hybrid branch predictor.
// Used by the predictor top level and by its port checker; depends on nothing.
`default_nettype none

package hbp_pkg;

	// Table sizes, expressed as the largest index width of each table.
	localparam int MAX_BIMODAL_BITS = 12;
	localparam int MAX_GSHARE_BITS  = 12;
	localparam int MAX_CHOOSER_BITS = 12;

	localparam int BIDX_W = MAX_BIMODAL_BITS;
	localparam int GIDX_W = MAX_GSHARE_BITS;
	localparam int CIDX_W = MAX_CHOOSER_BITS;

	localparam int BIM_DEPTH = 1 << BIDX_W;
	localparam int GSH_DEPTH = 1 << GIDX_W;
	localparam int CHO_DEPTH = 1 << CIDX_W;

	// The clear sweep covers the largest table; smaller ones are swept repeatedly.
	localparam int MAX_IDX_W = (BIDX_W > GIDX_W) ?
		((BIDX_W > CIDX_W) ? BIDX_W : CIDX_W) :
		((GIDX_W > CIDX_W) ? GIDX_W : CIDX_W);

	// Configuration registers.
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int MODE_W    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_BIMODAL_BITS,
		CFG_GSHARE_BITS,
		CFG_HISTORY_BITS,
		CFG_CHOOSER_BITS
	} cfg_idx_t;

	// Predictor mode codes; the fourth code behaves as hybrid.
	typedef enum logic [MODE_W-1:0] {
		MODE_BIMODAL,
		MODE_GSHARE,
		MODE_HYBRID,
		MODE_HYBRID_ALT
	} mode_t;

	localparam logic [CFG_W-1:0] RST_BIMODAL_BITS = 4'd12;
	localparam logic [CFG_W-1:0] RST_GSHARE_BITS  = 4'd12;
	localparam logic [CFG_W-1:0] RST_HISTORY_BITS = 4'd8;
	localparam logic [CFG_W-1:0] RST_CHOOSER_BITS = 4'd12;

	// Two-bit saturating counters.
	typedef logic [1:0] ctr_t;
	localparam ctr_t CTR_MAX     = 2'd3;
	localparam ctr_t CTR_MIN     = 2'd0;
	localparam ctr_t BIM_RESET   = 2'd2;
	localparam ctr_t GSH_RESET   = 2'd2;
	localparam ctr_t CHO_RESET   = 2'd1;

	// Stream payloads.
	localparam int ADDR_W   = 32;
	localparam int TOTAL_W  = 32;
	localparam int IN_W     = ADDR_W + 1;
	localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W    = 2 + 2 * TOTAL_W;
	localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

	// Output queue.
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [TOTAL_W-1:0] misprediction_total;
		logic [TOTAL_W-1:0] prediction_total;
		logic               mispredicted;
		logic               predicted_taken;
	} result_t;

	function automatic ctr_t sat_train(input ctr_t c, input logic t);
		ctr_t r;
		if (t) begin
			r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
		end else begin
			r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
		end
		return r;
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v, input logic en);
		logic [TOTAL_W-1:0] r;
		r = (en && (v != {TOTAL_W{1'b1}})) ? v + {{(TOTAL_W-1){1'b0}}, 1'b1} : v;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/hybrid_branch_predictor.sv
// Hybrid bimodal / gshare branch predictor top level with its tables and output queue.
// Depends on hbp_pkg for table sizes, codes and counter helpers.
`default_nettype none

// The predictor takes one resolved branch per transfer on the s_ side (address and
// outcome), predicts it with the bimodal table, the gshare table or both under a
// chooser, trains the tables and returns the prediction, a mispredict flag and two
// saturating running totals as one transfer on the m_ side. It accepts one branch
// every clock cycle while s_tready is high: the three counter tables are read in the
// accept cycle, and the read-modify-write completes in the next cycle, with a bypass
// from the last write so that back-to-back branches to the same entry see each
// other's training. A result is registered in stage 1 and then written into a
// three-entry queue that drives m_tvalid, so input keeps flowing while the consumer
// stalls briefly. After reset the tables are swept to their reset values, one entry
// per cycle; s_tready stays low during that sweep while configuration writes are
// taken as usual. The user must write configuration only when no branch is in
// flight; the block itself does not enforce it.
module hybrid_branch_predictor (
	input  wire                             clk,
	input  wire                             arst_n,
	// s_tdata, lowest bit up: branch_address[31:0], taken, zero padding
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [hbp_pkg::IN_TD_W-1:0]     s_tdata,
	// m_tdata, lowest bit up: predicted_taken, mispredicted, prediction_total[31:0],
	// misprediction_total[31:0], zero padding
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [hbp_pkg::OUT_TD_W-1:0]    m_tdata,
	input  wire                             cfg_we,
	input  wire  [hbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [hbp_pkg::CFG_W-1:0]       cfg_data
);
	import hbp_pkg::*;

	// Configuration registers.
	mode_t            mode_q;
	logic [CFG_W-1:0] bim_bits_q;
	logic [CFG_W-1:0] gsh_bits_q;
	logic [CFG_W-1:0] hist_bits_q;
	logic [CFG_W-1:0] cho_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_BIMODAL;
			bim_bits_q  <= RST_BIMODAL_BITS;
			gsh_bits_q  <= RST_GSHARE_BITS;
			hist_bits_q <= RST_HISTORY_BITS;
			cho_bits_q  <= RST_CHOOSER_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:         mode_q      <= mode_t'(cfg_data[MODE_W-1:0]);
				CFG_BIMODAL_BITS: bim_bits_q  <= cfg_data;
				CFG_GSHARE_BITS:  gsh_bits_q  <= cfg_data;
				CFG_HISTORY_BITS: hist_bits_q <= cfg_data;
				CFG_CHOOSER_BITS: cho_bits_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective index widths. A width above its table size uses the whole table, and
	// the history never reaches beyond the gshare index.
	logic [CFG_W-1:0] mbits, gbits, cbits, hbits;

	always_comb begin
		mbits = (32'(bim_bits_q) > MAX_BIMODAL_BITS) ? CFG_W'(MAX_BIMODAL_BITS) : bim_bits_q;
		gbits = (32'(gsh_bits_q) > MAX_GSHARE_BITS) ? CFG_W'(MAX_GSHARE_BITS) : gsh_bits_q;
		cbits = (32'(cho_bits_q) > MAX_CHOOSER_BITS) ? CFG_W'(MAX_CHOOSER_BITS) : cho_bits_q;
		hbits = (hist_bits_q > gbits) ? gbits : hist_bits_q;
	end

	// Clear sweep after reset.
	logic                 clearing_q;
	logic [MAX_IDX_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + {{(MAX_IDX_W-1){1'b0}}, 1'b1};
			if (clr_q == {MAX_IDX_W{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Input side: form the table indices and, outside bimodal mode, advance the global
	// history at the accept edge. The history depends only on the outcome, so it is
	// ready for the very next branch.
	logic                 s_xfer;
	logic                 s1_valid;
	logic [OUT_CNT_W-1:0] q_count;
	logic [OUT_CNT_W:0]   occupancy;

	assign occupancy = {1'b0, q_count} + {{OUT_CNT_W{1'b0}}, s1_valid};
	assign s_tready  = !clearing_q && (32'(occupancy) <= OUT_DEPTH - 1);
	assign s_xfer    = s_tvalid && s_tready;

	logic [ADDR_W-3:0] word;
	logic              in_taken;
	logic [GIDX_W-1:0] hist_q;
	logic [GIDX_W-1:0] hmask, hist_m, hist_next;
	logic [BIDX_W-1:0] bidx;
	logic [GIDX_W-1:0] gidx;
	logic [CIDX_W-1:0] cidx;

	always_comb begin
		word     = s_tdata[ADDR_W-1:2];
		in_taken = s_tdata[ADDR_W];
		hmask    = ~({GIDX_W{1'b1}} << hbits);
		hist_m   = hist_q & hmask;
		bidx     = word[BIDX_W-1:0] & ~({BIDX_W{1'b1}} << mbits);
		cidx     = word[CIDX_W-1:0] & ~({CIDX_W{1'b1}} << cbits);
		gidx     = (word[GIDX_W-1:0] & ~({GIDX_W{1'b1}} << gbits)) ^ (hist_m << (gbits - hbits));
		if (hbits == '0) begin
			hist_next = '0;
		end else begin
			hist_next = ((hist_m >> 1) | ({{(GIDX_W-1){1'b0}}, in_taken} << (hbits - 1'b1)))
				& hmask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (s_xfer && (mode_q != MODE_BIMODAL)) begin
			hist_q <= hist_next;
		end
	end

	// Stage 1 control and indices.
	logic              taken_s1;
	mode_t             mode_s1;
	logic [BIDX_W-1:0] bidx_s1;
	logic [GIDX_W-1:0] gidx_s1;
	logic [CIDX_W-1:0] cidx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= s_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			taken_s1 <= in_taken;
			mode_s1  <= mode_q;
			bidx_s1  <= bidx;
			gidx_s1  <= gidx;
			cidx_s1  <= cidx;
		end
	end

	// Counter tables: read at the accept edge, written back from stage 1 or by the
	// clear sweep. A read sees the contents from before a write at the same edge.
	ctr_t bim_mem [BIM_DEPTH];
	ctr_t gsh_mem [GSH_DEPTH];
	ctr_t cho_mem [CHO_DEPTH];
	ctr_t bim_rd_s1, gsh_rd_s1, cho_rd_s1;

	logic bim_we, gsh_we, cho_we;
	ctr_t bim_new, gsh_new, cho_new;

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			bim_rd_s1 <= bim_mem[bidx];
		end
		if (clearing_q) begin
			bim_mem[clr_q[BIDX_W-1:0]] <= BIM_RESET;
		end else if (bim_we) begin
			bim_mem[bidx_s1] <= bim_new;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			gsh_rd_s1 <= gsh_mem[gidx];
		end
		if (clearing_q) begin
			gsh_mem[clr_q[GIDX_W-1:0]] <= GSH_RESET;
		end else if (gsh_we) begin
			gsh_mem[gidx_s1] <= gsh_new;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cho_rd_s1 <= cho_mem[cidx];
		end
		if (clearing_q) begin
			cho_mem[clr_q[CIDX_W-1:0]] <= CHO_RESET;
		end else if (cho_we) begin
			cho_mem[cidx_s1] <= cho_new;
		end
	end

	// Last write to each table. Its data is the current contents of that entry, so
	// it covers the write that lands on the same edge as the stage 1 read.
	logic              bim_wv_q, gsh_wv_q, cho_wv_q;
	logic [BIDX_W-1:0] bim_wa_q;
	logic [GIDX_W-1:0] gsh_wa_q;
	logic [CIDX_W-1:0] cho_wa_q;
	ctr_t              bim_wd_q, gsh_wd_q, cho_wd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bim_wv_q <= 1'b0;
			gsh_wv_q <= 1'b0;
			cho_wv_q <= 1'b0;
		end else begin
			if (bim_we) bim_wv_q <= 1'b1;
			if (gsh_we) gsh_wv_q <= 1'b1;
			if (cho_we) cho_wv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bim_we) begin
			bim_wa_q <= bidx_s1;
			bim_wd_q <= bim_new;
		end
		if (gsh_we) begin
			gsh_wa_q <= gidx_s1;
			gsh_wd_q <= gsh_new;
		end
		if (cho_we) begin
			cho_wa_q <= cidx_s1;
			cho_wd_q <= cho_new;
		end
	end

	// Stage 1: prediction, training and running totals.
	ctr_t               bim_cur, gsh_cur, cho_cur;
	logic               pb, pg, use_g, is_hybrid, pred, mis;
	logic [TOTAL_W-1:0] pred_total_q, mis_total_q;
	logic [TOTAL_W-1:0] pred_total_nx, mis_total_nx;

	always_comb begin
		bim_cur = (bim_wv_q && (bim_wa_q == bidx_s1)) ? bim_wd_q : bim_rd_s1;
		gsh_cur = (gsh_wv_q && (gsh_wa_q == gidx_s1)) ? gsh_wd_q : gsh_rd_s1;
		cho_cur = (cho_wv_q && (cho_wa_q == cidx_s1)) ? cho_wd_q : cho_rd_s1;
		pb        = bim_cur[1];
		pg        = gsh_cur[1];
		is_hybrid = (mode_s1 == MODE_HYBRID) || (mode_s1 == MODE_HYBRID_ALT);
		use_g     = (mode_s1 == MODE_GSHARE) || (is_hybrid && cho_cur[1]);
		pred      = use_g ? pg : pb;
		mis       = pred != taken_s1;

		bim_new = sat_train(bim_cur, taken_s1);
		gsh_new = sat_train(gsh_cur, taken_s1);
		// The chooser moves toward gshare when only gshare was right, and toward
		// bimodal when only bimodal was right.
		if ((pb == taken_s1) && (pg != taken_s1)) begin
			cho_new = sat_train(cho_cur, 1'b0);
		end else if ((pb != taken_s1) && (pg == taken_s1)) begin
			cho_new = sat_train(cho_cur, 1'b1);
		end else begin
			cho_new = cho_cur;
		end
		bim_we = s1_valid && !use_g;
		gsh_we = s1_valid && use_g;
		cho_we = s1_valid && is_hybrid;

		pred_total_nx = sat_inc(pred_total_q, 1'b1);
		mis_total_nx  = sat_inc(mis_total_q, mis);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_total_q <= '0;
			mis_total_q  <= '0;
		end else if (s1_valid) begin
			pred_total_q <= pred_total_nx;
			mis_total_q  <= mis_total_nx;
		end
	end

	// Output queue. Stage 1 always has room here, because input is held back while
	// the queue and stage 1 together could overfill it.
	result_t              q_mem [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] q_wp_q, q_rp_q;
	logic                 m_xfer;
	result_t              res_s1;

	assign m_xfer = m_tvalid && m_tready;

	always_comb begin
		res_s1.predicted_taken     = pred;
		res_s1.mispredicted        = mis;
		res_s1.prediction_total    = pred_total_nx;
		res_s1.misprediction_total = mis_total_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q  <= '0;
			q_rp_q  <= '0;
			q_count <= '0;
		end else begin
			if (s1_valid) begin
				q_wp_q <= (q_wp_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : q_wp_q + 1'b1;
			end
			if (m_xfer) begin
				q_rp_q <= (q_rp_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : q_rp_q + 1'b1;
			end
			if (s1_valid && !m_xfer) begin
				q_count <= q_count + 1'b1;
			end else if (!s1_valid && m_xfer) begin
				q_count <= q_count - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			q_mem[q_wp_q] <= res_s1;
		end
	end

	assign m_tvalid = q_count != '0;
	assign m_tdata  = OUT_TD_W'(q_mem[q_rp_q]);

endmodule

`default_nettype wire

// File: rtl/hbp_checker.sv
// Port-level checker for the hybrid branch predictor, bound to its top level.
// Depends on hbp_pkg for payload widths.
`default_nettype none

module hbp_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [hbp_pkg::OUT_TD_W-1:0]   m_tdata
);
	import hbp_pkg::*;

	logic               s_xfer, m_xfer;
	result_t            res;
	logic [2:0]         inflight_q;
	logic               seen_q;
	logic [TOTAL_W-1:0] last_pt_q, last_mt_q;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;
	assign res    = result_t'(m_tdata[OUT_W-1:0]);

	// Branches accepted but not yet returned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			seen_q     <= 1'b0;
			last_pt_q  <= '0;
			last_mt_q  <= '0;
		end else begin
			if (s_xfer && !m_xfer) begin
				inflight_q <= inflight_q + 3'd1;
			end else if (!s_xfer && m_xfer) begin
				inflight_q <= inflight_q - 3'd1;
			end
			if (m_xfer) begin
				seen_q    <= 1'b1;
				last_pt_q <= res.prediction_total;
				last_mt_q <= res.misprediction_total;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer |-> inflight_q != 3'd0)
		else $error("result transfer without a pending branch");

	a_pred_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && seen_q |->
			(res.prediction_total == last_pt_q + 32'd1) ||
			((last_pt_q == {TOTAL_W{1'b1}}) && (res.prediction_total == last_pt_q)))
		else $error("prediction total did not advance by one");

	a_mis_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && seen_q |->
			(res.misprediction_total == last_mt_q + {31'd0, res.mispredicted}) ||
			((last_mt_q == {TOTAL_W{1'b1}}) && (res.misprediction_total == last_mt_q)))
		else $error("misprediction total does not follow the mispredict flag");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (.*);

`default_nettype wire
